@@ hw/rtl/ptmr_pkg.sv @@
// ----------------------------------------------------------------------------
// ptmr_pkg
// shared types and codes of the phase and frequency correct pwm timer
// ----------------------------------------------------------------------------
`default_nettype none

package ptmr_pkg;

  localparam int CNT_W   = 16;
  localparam int WAVE_W  = 4;
  localparam int MASK_W  = 4;

  typedef logic [1:0]        cmd_t;
  typedef logic [1:0]        chan_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [WAVE_W-1:0] wave_t;
  typedef logic [MASK_W-1:0] mask_t;

  localparam cmd_t CMD_TICK    = 2'd0;
  localparam cmd_t CMD_COMPARE = 2'd1;
  localparam cmd_t CMD_TOP     = 2'd2;
  localparam cmd_t CMD_NONE    = 2'd3;

  localparam count_t TOP_RESET     = 16'hFFFF;
  localparam count_t COMPARE_RESET = 16'h0003;
  localparam mask_t  MASK_RESET    = 4'hF;

  // one request as it is committed to the timer state
  typedef struct packed {
    logic   fire;
    cmd_t   cmd;
    chan_t  channel;
    count_t value;
  } op_t;

  // counter status after the committed request
  typedef struct packed {
    count_t count;
    logic   bottom;
    logic   down;
  } cnt_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptmr_item_if.sv @@
// ----------------------------------------------------------------------------
// ptmr_item_if
// request channel: tick, compare write or top write
// ----------------------------------------------------------------------------
`default_nettype none

interface ptmr_item_if;
  logic             valid;
  logic             ready;
  ptmr_pkg::cmd_t   cmd;
  ptmr_pkg::chan_t  channel;
  ptmr_pkg::count_t value;

  modport source(output valid, output cmd, output channel, output value, input ready);
  modport sink(input valid, input cmd, input channel, input value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ptmr_result_if.sv @@
// ----------------------------------------------------------------------------
// ptmr_result_if
// result channel: waveform bits and counter status
// ----------------------------------------------------------------------------
`default_nettype none

interface ptmr_result_if;
  logic             valid;
  logic             ready;
  ptmr_pkg::wave_t  wave_out;
  ptmr_pkg::count_t count_now;
  logic             at_bottom;
  logic             counting_down;

  modport source(output valid, output wave_out, output count_now, output at_bottom,
                 output counting_down, input ready);
  modport sink(input valid, input wave_out, input count_now, input at_bottom,
               input counting_down, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ptmr_counter.sv @@
// ----------------------------------------------------------------------------
// ptmr_counter
// prescaler, up/down counter and top register
// ----------------------------------------------------------------------------
`default_nettype none

module ptmr_counter #(
  parameter int PRESCALE_DIV = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire ptmr_pkg::op_t op,
  output ptmr_pkg::cnt_t    status
);

  localparam int PW = (PRESCALE_DIV > 1) ? $clog2(PRESCALE_DIV) : 1;
  localparam logic [PW-1:0] PRESCALE_LAST = PW'(PRESCALE_DIV - 1);

  logic [PW-1:0]    prescale_count;
  logic [PW-1:0]    prescale_count_next;
  ptmr_pkg::count_t counter;
  ptmr_pkg::count_t top_value;
  ptmr_pkg::count_t top_value_next;
  logic             down_flag;
  logic             step;
  ptmr_pkg::count_t cnt_step;
  logic             down_step;

  always_comb begin
    prescale_count_next = prescale_count;
    top_value_next      = top_value;
    step                = 1'b0;
    unique case (op.cmd)
      ptmr_pkg::CMD_TICK: begin
        if (prescale_count == PRESCALE_LAST) begin
          prescale_count_next = '0;
          step                = 1'b1;
        end else begin
          prescale_count_next = PW'(prescale_count + 1'b1);
        end
      end
      ptmr_pkg::CMD_TOP: begin
        top_value_next = op.value;
      end
      default: begin
      end
    endcase
  end

  // one counter step; turnaround at top, also when top was lowered below count
  always_comb begin
    cnt_step  = counter;
    down_step = down_flag;
    if (!down_flag && counter < top_value) begin
      cnt_step  = ptmr_pkg::CNT_W'(counter + 1'b1);
      down_step = (cnt_step == top_value);
    end else begin
      down_step = 1'b1;
      if (counter != '0) begin
        cnt_step = ptmr_pkg::CNT_W'(counter - 1'b1);
      end
    end
  end

  always_comb begin
    status.count  = counter;
    status.bottom = 1'b0;
    status.down   = down_flag;
    if (step) begin
      status.count  = cnt_step;
      status.bottom = down_step && (cnt_step == '0);
      status.down   = down_step && (cnt_step != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      counter        <= '0;
      down_flag      <= 1'b0;
      top_value      <= ptmr_pkg::TOP_RESET;
    end else if (op.fire) begin
      prescale_count <= prescale_count_next;
      counter        <= status.count;
      down_flag      <= status.down;
      top_value      <= top_value_next;
    end
  end

  a_down_nonzero: assert property (@(posedge clk) disable iff (rst)
    down_flag |-> counter != '0)
    else $error("counting down with counter at zero");

  a_bottom_on_tick: assert property (@(posedge clk) disable iff (rst)
    status.bottom |-> op.cmd == ptmr_pkg::CMD_TICK && prescale_count == PRESCALE_LAST)
    else $error("bottom outside a prescaled step");

endmodule

`default_nettype wire

@@ hw/rtl/ptmr_compare.sv @@
// ----------------------------------------------------------------------------
// ptmr_compare
// pending and active compare registers and waveform compare
// ----------------------------------------------------------------------------
`default_nettype none

module ptmr_compare #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ptmr_pkg::op_t   op,
  input  wire ptmr_pkg::cnt_t  status,
  input  wire ptmr_pkg::mask_t mask,
  output ptmr_pkg::wave_t      wave
);

  // only channels 0..3 can be written or seen
  localparam int NUM_LIVE = (NUM_CHANNELS < ptmr_pkg::WAVE_W) ? NUM_CHANNELS
                                                               : ptmr_pkg::WAVE_W;

  ptmr_pkg::count_t compare_pending [NUM_LIVE];
  ptmr_pkg::count_t compare_active  [NUM_LIVE];
  ptmr_pkg::count_t active_next     [NUM_LIVE];

  for (genvar c = 0; c < ptmr_pkg::WAVE_W; c++) begin : g_chan
    if (c < NUM_LIVE) begin : g_live
      assign active_next[c] = status.bottom ? compare_pending[c] : compare_active[c];
      assign wave[c]        = mask[c] && (status.count < active_next[c]);

      always_ff @(posedge clk) begin
        if (rst) begin
          compare_pending[c] <= ptmr_pkg::COMPARE_RESET;
          compare_active[c]  <= ptmr_pkg::COMPARE_RESET;
        end else if (op.fire) begin
          if (op.cmd == ptmr_pkg::CMD_COMPARE && op.channel == 2'(c)) begin
            compare_pending[c] <= op.value;
          end
          compare_active[c] <= active_next[c];
        end
      end
    end else begin : g_dead
      assign wave[c] = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/phase_freq_correct_pwm_timer.sv @@
// ----------------------------------------------------------------------------
// phase_freq_correct_pwm_timer
// 16-bit phase and frequency correct pwm timer with prescaler and compare outputs
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  item      in         valid/ready    cmd, channel, value
//  result    out        valid/ready    wave_out, count_now, at_bottom, counting_down
//  cfg       in         cfg_wr_en      cfg_wr_data (output enable mask)
//
//  one request per cycle unless result stalls; input register, then result register
//  the timer state commits when a request moves from the input to the result register
//  a stalled result holds the input register; item.ready drops only when both are full
//  synchronous reset restores all but the payload registers; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module phase_freq_correct_pwm_timer #(
  parameter int PRESCALE_DIV = 64,
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire ptmr_pkg::mask_t cfg_wr_data,
  ptmr_item_if.sink            item,
  ptmr_result_if.source        result
);

  ptmr_pkg::mask_t  mask;
  logic             s1_valid;
  ptmr_pkg::cmd_t   s1_cmd;
  ptmr_pkg::chan_t  s1_channel;
  ptmr_pkg::count_t s1_value;
  logic             out_valid;
  ptmr_pkg::wave_t  out_wave;
  ptmr_pkg::count_t out_count;
  logic             out_bottom;
  logic             out_down;
  logic             adv;
  ptmr_pkg::op_t    op;
  ptmr_pkg::cnt_t   status;
  ptmr_pkg::wave_t  wave;

  assign adv        = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || adv;

  assign op.fire    = adv;
  assign op.cmd     = s1_cmd;
  assign op.channel = s1_channel;
  assign op.value   = s1_value;

  ptmr_counter #(
    .PRESCALE_DIV(PRESCALE_DIV)
  ) u_counter (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .status(status)
  );

  ptmr_compare #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_compare (
    .clk   (clk),
    .rst   (rst),
    .op    (op),
    .status(status),
    .mask  (mask),
    .wave  (wave)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= ptmr_pkg::MASK_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        mask <= cfg_wr_data;
      end
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_cmd     <= item.cmd;
      s1_channel <= item.channel;
      s1_value   <= item.value;
    end
    if (adv) begin
      out_wave   <= wave;
      out_count  <= status.count;
      out_bottom <= status.bottom;
      out_down   <= status.down;
    end
  end

  assign result.valid         = out_valid;
  assign result.wave_out      = out_wave;
  assign result.count_now     = out_count;
  assign result.at_bottom     = out_bottom;
  assign result.counting_down = out_down;

  a_bottom_status: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.at_bottom |-> result.count_now == '0 && !result.counting_down)
    else $error("bottom result with nonzero count or down direction");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !result.ready |-> !item.ready)
    else $error("request taken while both stages are blocked");

  a_adv_fills: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("result register empty after a committed request");

endmodule

`default_nettype wire
